// ===== src/rpwu_pkg.sv =====
// Shared types, constants and helpers for the RPROP weight update engine.
// No dependencies; every other file imports this package.
package rpwu_pkg;

  // Table size default and fixed field widths
  localparam int unsigned NUM_WEIGHTS_DEF = 1024;
  localparam int IDX_W     = 10;
  localparam int DATA_W    = 32;
  localparam int STEP_W    = 31;
  localparam int DECAY_W   = 25;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 31;
  // Q16.24 product of Q8.24 operands after the 24-bit floor shift
  localparam int TERM_W    = 40;
  localparam int SUM_W     = TERM_W + 1;
  // step/5 is below 2^29 for any 31-bit step
  localparam int QUOT_W    = 29;

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Arithmetic constants
  localparam logic [DECAY_W:0]  FRAC_ONE     = 26'd16777216;
  localparam logic [STEP_W-1:0] STEP_FLOOR   = 31'd17;
  localparam logic [31:0]       RECIP5       = 32'd3435973837;
  localparam int                RECIP5_SHIFT = 34;
  localparam int                PROD5_W      = STEP_W + 32;

  // Configuration reset values
  localparam logic [STEP_W-1:0]  INITIAL_STEP_RST = 31'd1677722;
  localparam logic [STEP_W-1:0]  MAX_STEP_RST     = 31'd838860800;
  localparam logic [DECAY_W-1:0] DECAY_RST        = 25'd16777216;

  typedef enum logic [1:0] {
    OP_INIT   = 2'd0,
    OP_ACCUM  = 2'd1,
    OP_UPDATE = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INITIAL_STEP = 2'd0,
    REG_MAX_STEP     = 2'd1,
    REG_DECAY_FACTOR = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_CALC,
    BK_COMMIT
  } back_state_t;

  typedef struct packed {
    logic [STEP_W-1:0]  initial_step;
    logic [STEP_W-1:0]  max_step;
    logic [DECAY_W-1:0] decay_factor;
  } cfg_t;

  // One classified request as it travels through the queue
  typedef struct packed {
    op_t                       opcode;
    logic [IDX_W-1:0]          index;
    logic signed [DATA_W-1:0]  weight;
    logic signed [TERM_W-1:0]  term;
  } work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Clamp a wide signed sum to the signed 32-bit range
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic fits;
    fits = (&v[SUM_W-1:DATA_W-1]) || ~(|v[SUM_W-1:DATA_W-1]);
    if (fits) begin
      return v[DATA_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== src/rpwu_if.sv =====
// Valid/ready channel interfaces for requests and results.
// Depends on rpwu_pkg for field widths.
interface rpwu_in_if;
  import rpwu_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [1:0]                opcode;
  logic [IDX_W-1:0]          index;
  logic signed [DATA_W-1:0]  error_term;
  logic signed [DATA_W-1:0]  activation;
  logic signed [DATA_W-1:0]  weight;

  modport source (output valid, opcode, index, error_term, activation, weight, input ready);
  modport sink   (input valid, opcode, index, error_term, activation, weight, output ready);
endinterface

interface rpwu_out_if;
  import rpwu_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [IDX_W-1:0]          out_index;
  logic signed [DATA_W-1:0]  new_weight;
  logic signed [DATA_W-1:0]  weight_change;
  logic [STEP_W-1:0]         step_size;

  modport source (output valid, out_index, new_weight, weight_change, step_size, input ready);
  modport sink   (input valid, out_index, new_weight, weight_change, step_size, output ready);
endinterface

// ===== src/rpwu_front.sv =====
// Front end: accepts requests, drops unknown opcodes and out-of-range indexes,
// forms the Q16.24 product and pushes into the queue. Uses rpwu_pkg, rpwu_in_if.
module rpwu_front
  import rpwu_pkg::*;
#(
  parameter int unsigned NUM_WEIGHTS = NUM_WEIGHTS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  rpwu_in_if.sink      item,
  input  qstat_t       qstat,
  output logic         q_push,
  output work_t        q_data
);

  localparam logic [16:0] NumW = 17'(NUM_WEIGHTS);

  logic                      stg_valid;
  work_t                     stg;
  logic                      keep;
  logic                      accept;
  logic signed [DECAY_W:0]   dec;
  logic signed [DATA_W-1:0]  mul_a;
  logic signed [DATA_W-1:0]  mul_b;
  logic signed [63:0]        prod;

  // Classify: only known opcodes on existing entries go on
  always_comb begin
    keep = ((item.opcode == OP_INIT) || (item.opcode == OP_ACCUM) ||
            (item.opcode == OP_UPDATE)) && (17'(item.index) < NumW);
  end

  // One multiplier: error*activation, or (1 - decay)*weight for updates
  always_comb begin
    dec = $signed(FRAC_ONE) - $signed({1'b0, cfg.decay_factor});
    if (item.opcode == OP_UPDATE) begin
      mul_a = item.weight;
      mul_b = {{(DATA_W-DECAY_W-1){dec[DECAY_W]}}, dec};
    end else begin
      mul_a = item.error_term;
      mul_b = item.activation;
    end
    prod = mul_a * mul_b;
  end

  assign item.ready = !stg_valid || !qstat.full;
  assign accept     = item.valid && item.ready;
  assign q_push     = stg_valid && !qstat.full;
  assign q_data     = stg;

  // Stage register; arithmetic shift floors the product
  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (accept) begin
      stg_valid <= keep;
    end else if (q_push) begin
      stg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      stg.opcode <= op_t'(item.opcode);
      stg.index  <= item.index;
      stg.weight <= item.weight;
      stg.term   <= prod[63:24];
    end
  end

endmodule

// ===== src/rpwu_queue.sv =====
// Short request queue between the front end and the table sequencer.
// Uses rpwu_pkg for the entry type and depth.
module rpwu_queue
  import rpwu_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  work_t  data_in,
  input  logic   pop,
  output work_t  data_out,
  output qstat_t qstat
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  work_t           slots [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign qstat.full  = (count == CW'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign data_out    = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= data_in;
    end
  end

endmodule

// ===== src/rpwu_back.sv =====
// Back end: per-weight tables and the read-modify-write sequencer that runs
// init, accumulate and update requests. Uses rpwu_pkg and rpwu_out_if.
module rpwu_back
  import rpwu_pkg::*;
#(
  parameter int unsigned NUM_WEIGHTS = NUM_WEIGHTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  qstat_t      qstat,
  input  work_t       q_data,
  output logic        q_pop,
  rpwu_out_if.source  result
);

  localparam int AW = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;

  // Tables
  logic [STEP_W-1:0]         step_mem   [NUM_WEIGHTS];
  logic signed [DATA_W-1:0]  change_mem [NUM_WEIGHTS];
  logic signed [DATA_W-1:0]  grad_mem   [NUM_WEIGHTS];

  back_state_t               state;
  back_state_t               state_next;
  work_t                     cur;
  logic [AW-1:0]             addr;

  logic [STEP_W-1:0]         rd_step;
  logic signed [DATA_W-1:0]  rd_change;
  logic signed [DATA_W-1:0]  rd_grad;

  logic signed [DATA_W-1:0]  grad_r;
  logic [QUOT_W-1:0]         quot_r;

  logic signed [SUM_W-1:0]   grad_ext;
  logic signed [SUM_W-1:0]   term_ext;
  logic signed [DATA_W-1:0]  grad_acc;
  logic signed [DATA_W-1:0]  grad_upd;
  logic [PROD5_W-1:0]        prod5;

  logic                      gneg;
  logic                      lneg;
  logic                      both_nz;
  logic [STEP_W:0]           grown;
  logic [STEP_W-1:0]         halved;
  logic [STEP_W-1:0]         new_step;
  logic [STEP_W-1:0]         mag;
  logic signed [DATA_W-1:0]  mag_s;
  logic signed [DATA_W-1:0]  new_change;
  logic signed [DATA_W-1:0]  new_w;
  logic                      out_free;

  logic                      we_all;
  logic                      we_grad;
  logic                      load_calc;
  logic                      load_out;
  logic [STEP_W-1:0]         wr_step;
  logic signed [DATA_W-1:0]  wr_change;
  logic signed [DATA_W-1:0]  wr_grad;

  logic                      res_valid;
  logic [IDX_W-1:0]          res_index;
  logic signed [DATA_W-1:0]  res_weight;
  logic signed [DATA_W-1:0]  res_change;
  logic [STEP_W-1:0]         res_step;

  assign addr     = AW'(cur.index);
  assign out_free = !res_valid || result.ready;

  // Table read, registered
  always_ff @(posedge clk) begin
    rd_step   <= step_mem[addr];
    rd_change <= change_mem[addr];
    rd_grad   <= grad_mem[addr];
  end

  // Table write
  always_ff @(posedge clk) begin
    if (we_all) begin
      step_mem[addr]   <= wr_step;
      change_mem[addr] <= wr_change;
    end
    if (we_all || we_grad) begin
      grad_mem[addr] <= wr_grad;
    end
  end

  // Gradient sums and step/5 by reciprocal multiply
  always_comb begin
    grad_ext = {{(SUM_W-DATA_W){rd_grad[DATA_W-1]}}, rd_grad};
    term_ext = {cur.term[TERM_W-1], cur.term};
    grad_acc = sat32(grad_ext - term_ext);
    grad_upd = sat32(grad_ext + term_ext);
    prod5    = PROD5_W'(rd_step) * PROD5_W'(RECIP5);
  end

  // Adaptation from the registered gradient and last change
  always_comb begin
    gneg    = grad_r[DATA_W-1];
    lneg    = rd_change[DATA_W-1];
    both_nz = (grad_r != '0) && (rd_change != '0);
    grown   = {1'b0, rd_step} + (STEP_W+1)'(quot_r);
    halved  = rd_step >> 1;
    if (halved < STEP_FLOOR) begin
      halved = STEP_FLOOR;
    end
    priority if (both_nz && (gneg != lneg)) begin
      new_step = (grown > {1'b0, cfg.max_step}) ? cfg.max_step : grown[STEP_W-1:0];
      mag      = new_step;
    end else if (both_nz) begin
      new_step = halved;
      mag      = '0;
    end else begin
      new_step = rd_step;
      mag      = rd_step;
    end
    mag_s      = $signed({1'b0, mag});
    new_change = gneg ? mag_s : -mag_s;
    new_w      = sat32({{(SUM_W-DATA_W){cur.weight[DATA_W-1]}}, cur.weight} +
                       {{(SUM_W-DATA_W){new_change[DATA_W-1]}}, new_change});
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!qstat.empty) begin
          state_next = BK_READ;
        end
      end
      BK_READ: begin
        state_next = BK_CALC;
      end
      BK_CALC: begin
        state_next = (cur.opcode == OP_UPDATE) ? BK_COMMIT : BK_IDLE;
      end
      BK_COMMIT: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    q_pop     = 1'b0;
    we_all    = 1'b0;
    we_grad   = 1'b0;
    load_calc = 1'b0;
    load_out  = 1'b0;
    wr_step   = new_step;
    wr_change = new_change;
    wr_grad   = '0;
    unique case (state)
      BK_IDLE: begin
        q_pop = !qstat.empty;
      end
      BK_READ: begin
      end
      BK_CALC: begin
        load_calc = 1'b1;
        if (cur.opcode == OP_INIT) begin
          we_all    = 1'b1;
          wr_step   = cfg.initial_step;
          wr_change = '0;
        end else if (cur.opcode == OP_ACCUM) begin
          we_grad = 1'b1;
          wr_grad = grad_acc;
        end
      end
      BK_COMMIT: begin
        we_all   = out_free;
        load_out = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
    if (load_calc) begin
      grad_r <= grad_upd;
      quot_r <= prod5[RECIP5_SHIFT +: QUOT_W];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_out) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      res_index  <= cur.index;
      res_weight <= new_w;
      res_change <= new_change;
      res_step   <= new_step;
    end
  end

  assign result.valid         = res_valid;
  assign result.out_index     = res_index;
  assign result.new_weight    = res_weight;
  assign result.weight_change = res_change;
  assign result.step_size     = res_step;

endmodule

// ===== src/rprop_weight_update.sv =====
// Top level of the RPROP weight update engine: configuration registers and
// the front end, request queue and table sequencer. Uses rpwu_pkg, rpwu_if.
//
// Usage: requests arrive on the item channel (valid/ready) with an opcode
// (init, accumulate, update), a table index and the Q8.24 operands. Unknown
// opcodes and indexes at or above NUM_WEIGHTS are taken and dropped. Only
// update requests produce a request on the result channel.
// The front end takes a request every cycle while the four-entry queue has
// room; the table sequencer then steps through pop, read and compute states
// for an init or accumulate, with a write-back state added for an update
// (through the one table address), and takes no new request until done.
// From acceptance a request passes the front stage register, the queue and
// the sequencer's pop, read, compute and write-back states to result valid.
// The result sits in an output register; a stalled receiver holds the
// sequencer in its write-back step while the queue keeps filling, and the
// item channel drops ready once the queue and the front stage are full.
// Reset clears control state and loads the register defaults; table
// entries are undefined until an init request writes them.
// Configuration: cfg_we/cfg_index/cfg_data write one register per cycle.
module rprop_weight_update
  import rpwu_pkg::*;
#(
  parameter int unsigned NUM_WEIGHTS = NUM_WEIGHTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  rpwu_in_if.sink               item,
  rpwu_out_if.source            result
);

  cfg_t   cfg;
  qstat_t qstat;
  logic   q_push;
  logic   q_pop;
  work_t  push_data;
  work_t  pop_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.initial_step <= INITIAL_STEP_RST;
      cfg.max_step     <= MAX_STEP_RST;
      cfg.decay_factor <= DECAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INITIAL_STEP: cfg.initial_step <= cfg_data[STEP_W-1:0];
        REG_MAX_STEP:     cfg.max_step     <= cfg_data[STEP_W-1:0];
        REG_DECAY_FACTOR: cfg.decay_factor <= cfg_data[DECAY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rpwu_front #(
    .NUM_WEIGHTS (NUM_WEIGHTS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .item   (item),
    .qstat  (qstat),
    .q_push (q_push),
    .q_data (push_data)
  );

  rpwu_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .data_in  (push_data),
    .pop      (q_pop),
    .data_out (pop_data),
    .qstat    (qstat)
  );

  rpwu_back #(
    .NUM_WEIGHTS (NUM_WEIGHTS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .qstat  (qstat),
    .q_data (pop_data),
    .q_pop  (q_pop),
    .result (result)
  );

endmodule
